// File: design/bapx_pkg.sv
package bapx_pkg;

  localparam int COORD_W = 20;
  localparam int ROW_W   = 13;
  localparam int PPR_W   = 11;
  localparam int DIM_W   = 13;
  localparam int PIX_W   = 12;
  localparam int GRAY_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [ROW_W-1:0] ROW_MAX = 13'd8191;
  localparam logic [PPR_W-1:0] PPR_RST = 11'd1024;
  localparam logic [DIM_W-1:0] DIM_RST = 13'd1024;

  // square of one difference, sum of three squares, root, numerator, 2ab
  localparam int SQE_W  = 2 * (COORD_W + 1);
  localparam int SQ_W   = SQE_W + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int NUM_W  = SQ_W + 1;
  localparam int DEN_W  = SQ_W + 1;
  localparam int QUO_W  = 17;
  localparam int COS_W  = 18;
  localparam logic [QUO_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PPR    = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic             zero;
    logic             neg;
    logic [NUM_W-1:0] num;
  } sqrt_side_t;

  typedef struct packed {
    meta_t meta;
    logic  zero;
    logic  neg;
  } div_side_t;

  typedef logic signed [COS_W-1:0] cos_tab_t [256];

  localparam logic [63:0] PiQ32 = 64'd13493037705;
  localparam logic [63:0] TaylorDiv [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  function automatic logic [SQE_W-1:0] sqr(logic signed [COORD_W:0] v);
    logic [COORD_W:0] m;
    m = v[COORD_W] ? (~v + 1'b1) : v;
    return m * m;
  endfunction

  // cosine table in q2.16, taylor series in q30, mirrored about the middle
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] q;
    longint      sum;
    for (int g = 0; g < 128; g++) begin
      t = (64'(g) * PiQ32 + 64'd510) / 64'd1020;
      t2 = (t * t + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * t2) >> 30) / TaylorDiv[n-1];
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (64'(sum) + (64'd1 << 13)) >> 14;
      tab[g] = COS_W'(q);
      tab[255-g] = COS_W'(64'd0 - q);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// File: design/bapx_if.sv
interface bapx_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bapx_pkg::COORD_W-1:0] pos_x;
  logic signed [bapx_pkg::COORD_W-1:0] pos_y;
  logic signed [bapx_pkg::COORD_W-1:0] pos_z;
  logic                                frame_start;
  modport source (output valid, pos_x, pos_y, pos_z, frame_start, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, frame_start, output ready);
endinterface

interface bapx_out_if;
  logic                          valid;
  logic                          ready;
  logic [bapx_pkg::GRAY_W-1:0]   gray_level;
  logic [bapx_pkg::PIX_W-1:0]    pixel_row;
  logic [bapx_pkg::PIX_W-1:0]    pixel_col;
  modport source (output valid, gray_level, pixel_row, pixel_col, input ready);
  modport sink (input valid, gray_level, pixel_row, pixel_col, output ready);
endinterface

interface bapx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bapx_pkg::CFG_IDX_W-1:0]   index;
  logic [bapx_pkg::DIM_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/bapx_ram.sv
module bapx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bapx_isqrt2.sv
module bapx_isqrt2 #(
  parameter int STEPS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [bapx_pkg::SQ_W-1:0]         va_i,
  input  logic [bapx_pkg::SQ_W-1:0]         vb_i,
  input  bapx_pkg::sqrt_side_t              side_i,
  output logic                              vld_o,
  output logic [bapx_pkg::ROOT_W-1:0]       ra_o,
  output logic [bapx_pkg::ROOT_W-1:0]       rb_o,
  output bapx_pkg::sqrt_side_t              side_o
);

  localparam int VW  = bapx_pkg::SQ_W;
  localparam int RW  = bapx_pkg::ROOT_W;
  localparam int NST = (RW + STEPS - 1) / STEPS;

  typedef struct packed {
    logic [VW-1:0]   val;
    logic [RW+1:0]   rem;
    logic [RW-1:0]   root;
  } sqst_t;

  // one digit of the root per step, two radicand bits brought in
  function automatic sqst_t step(sqst_t s);
    sqst_t         o;
    logic [RW+1:0] r;
    logic [RW+1:0] trial;
    r = {s.rem[RW-1:0], s.val[VW-1 -: 2]};
    trial = {s.root, 2'b01};
    o.val = {s.val[VW-3:0], 2'b00};
    if (r >= trial) begin
      o.rem = r - trial;
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.root = {s.root[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic                 vld_q  [NST];
  sqst_t                sta_q  [NST];
  sqst_t                stb_q  [NST];
  bapx_pkg::sqrt_side_t side_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    sqst_t                a_in;
    sqst_t                b_in;
    sqst_t                a_nx;
    sqst_t                b_nx;
    bapx_pkg::sqrt_side_t sd_in;
    logic                 v_in;

    if (s == 0) begin : g_first
      assign a_in  = '{val: va_i, rem: '0, root: '0};
      assign b_in  = '{val: vb_i, rem: '0, root: '0};
      assign sd_in = side_i;
      assign v_in  = vld_i;
    end else begin : g_next
      assign a_in  = sta_q[s-1];
      assign b_in  = stb_q[s-1];
      assign sd_in = side_q[s-1];
      assign v_in  = vld_q[s-1];
    end

    always_comb begin
      a_nx = a_in;
      b_nx = b_in;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < RW) begin
          a_nx = step(a_nx);
          b_nx = step(b_nx);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sta_q[s]  <= a_nx;
        stb_q[s]  <= b_nx;
        side_q[s] <= sd_in;
      end
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign ra_o   = sta_q[NST-1].root;
  assign rb_o   = stb_q[NST-1].root;
  assign side_o = side_q[NST-1];

endmodule

// File: design/bapx_divq.sv
module bapx_divq #(
  parameter int STEPS = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic [bapx_pkg::NUM_W-1:0]      num_i,
  input  logic [bapx_pkg::DEN_W-1:0]      den_i,
  input  bapx_pkg::div_side_t             side_i,
  output logic                            vld_o,
  output logic [bapx_pkg::QUO_W-1:0]      quo_o,
  output logic                            ovf_o,
  output bapx_pkg::div_side_t             side_o
);

  localparam int DW  = bapx_pkg::DEN_W;
  localparam int RW  = DW + 1;
  localparam int QW  = bapx_pkg::QUO_W;
  localparam int NST = (QW + STEPS - 1) / STEPS;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [DW-1:0] d;
    logic [QW-1:0] q;
    logic          ovf;
  } dst_t;

  // restoring step; the first one works on the unshifted numerator
  function automatic dst_t step(dst_t s, logic first);
    dst_t          o;
    logic [RW-1:0] t;
    o = s;
    t = first ? s.r : {s.r[RW-2:0], 1'b0};
    if (t >= RW'(s.d)) begin
      o.r = t - RW'(s.d);
      o.q = {s.q[QW-2:0], 1'b1};
    end else begin
      o.r = t;
      o.q = {s.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic                vld_q  [NST+1];
  dst_t                st_q   [NST+1];
  bapx_pkg::div_side_t side_q [NST+1];

  // entry stage: quotient of two or more saturates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].r   <= RW'(num_i);
      st_q[0].d   <= den_i;
      st_q[0].q   <= '0;
      st_q[0].ovf <= RW'(num_i) >= {den_i, 1'b0};
      side_q[0]   <= side_i;
    end
  end

  for (genvar s = 1; s <= NST; s++) begin : g_st
    dst_t nx;

    always_comb begin
      nx = st_q[s-1];
      for (int k = 0; k < STEPS; k++) begin
        if ((s - 1) * STEPS + k < QW) begin
          nx = step(nx, ((s - 1) * STEPS + k) == 0);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s]   <= nx;
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[NST];
  assign quo_o  = st_q[NST].q;
  assign ovf_o  = st_q[NST].ovf;
  assign side_o = side_q[NST];

endmodule

// File: design/bapx_gray.sv
module bapx_gray #(
  parameter int STEPS = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic [bapx_pkg::QUO_W-1:0]      quo_i,
  input  logic                            ovf_i,
  input  bapx_pkg::div_side_t             side_i,
  output logic                            vld_o,
  output logic [bapx_pkg::GRAY_W-1:0]     gray_o,
  output bapx_pkg::meta_t                 meta_o
);

  localparam int GW  = bapx_pkg::GRAY_W;
  localparam int CW  = bapx_pkg::COS_W;
  localparam int NST = (GW + STEPS - 1) / STEPS;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic [GW-1:0]        res;
  } gst_t;

  logic                vld_q  [NST+1];
  gst_t                st_q   [NST+1];
  bapx_pkg::div_side_t side_q [NST+1];

  logic [bapx_pkg::QUO_W-1:0] cmag;

  // clamp to one and apply the sign
  always_comb begin
    cmag = (ovf_i || quo_i > bapx_pkg::ONE_Q16) ? bapx_pkg::ONE_Q16 : quo_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].c   <= side_i.neg ? -CW'(cmag) : CW'(cmag);
      st_q[0].res <= '0;
      side_q[0]   <= side_i;
    end
  end

  // table is non-increasing: find the last index whose entry is >= c, or 0 when zero is set
  for (genvar s = 1; s <= NST; s++) begin : g_st
    gst_t          nx;
    logic [GW-1:0] cand;

    always_comb begin
      nx = st_q[s-1];
      cand = '0;
      for (int k = 0; k < STEPS; k++) begin
        if ((s - 1) * STEPS + k < GW) begin
          cand = nx.res | (GW'(1) << (GW - 1 - ((s - 1) * STEPS + k)));
          if (bapx_pkg::COS_TAB[cand] >= nx.c) nx.res = cand;
        end
      end
      if (s == NST && side_q[s-1].zero) nx.res = '0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s]   <= nx;
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[NST];
  assign gray_o = st_q[NST].res;
  assign meta_o = side_q[NST].meta;

endmodule

// File: design/bearing_angle_pixel_stream_top.sv
// Bearing-angle image from an organized range-point stream. Points (x, y, z in signed
// millimetres) arrive row by row, frame_start marking the first point of a frame; the
// previous scan row is held in a line store of MAX_ROW_POINTS entries, written at the
// current column and read one column ahead in the same cycle. Each point from the second
// row on, except the last column of a row, yields one pixel: the angle between its beam
// and the segment to the previous row's next point, as gray 0..255 over 0..180 degrees,
// at the flipped position (height - row - 1, width - column - 1); a zero beam or segment
// gives gray 0, and pixels outside the image are dropped. One point is taken every cycle.
// It has four front stages (store read, squares, sums, difference), eight square-root
// stages (three root bits each), one multiply stage, seven divider stages (overflow
// check, then three quotient bits each) and five table-search stages. The whole pipeline
// holds while a finished pixel waits at the output. The line store needs no clearing
// after reset; the user writes configuration only while the block is idle (not enforced).
module bearing_angle_pixel_stream_top #(
  parameter int MAX_ROW_POINTS = 1024,
  parameter int MAX_IMAGE_DIM  = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bapx_cfg_if.sink     cfg_i,
  bapx_in_if.sink      pt_i,
  bapx_out_if.source   px_o
);

  localparam int AW = $clog2(MAX_ROW_POINTS);
  localparam int CW = AW + 1;
  localparam int DW = bapx_pkg::DIM_W;
  localparam int KW = bapx_pkg::COORD_W;

  // configuration
  logic [bapx_pkg::PPR_W-1:0] ppr_q;
  logic [DW-1:0]              w_q;
  logic [DW-1:0]              h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= bapx_pkg::PPR_RST;
      w_q   <= bapx_pkg::DIM_RST;
      h_q   <= bapx_pkg::DIM_RST;
    end else if (cfg_i.valid) begin
      unique case (bapx_pkg::cfg_reg_e'(cfg_i.index))
        bapx_pkg::CFG_PPR:    ppr_q <= cfg_i.data[bapx_pkg::PPR_W-1:0];
        bapx_pkg::CFG_WIDTH:  w_q   <= cfg_i.data;
        bapx_pkg::CFG_HEIGHT: h_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] ppr_eff;
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;

  always_comb begin
    if (ppr_q < bapx_pkg::PPR_W'(2)) ppr_eff = CW'(2);
    else if (32'(ppr_q) > MAX_ROW_POINTS) ppr_eff = CW'(MAX_ROW_POINTS);
    else ppr_eff = CW'(ppr_q);
    w_eff = (32'(w_q) > MAX_IMAGE_DIM) ? DW'(MAX_IMAGE_DIM) : w_q;
    h_eff = (32'(h_q) > MAX_IMAGE_DIM) ? DW'(MAX_IMAGE_DIM) : h_q;
  end

  // pipeline control
  logic en;
  logic out_vld;
  logic acc;

  assign en         = !out_vld || px_o.ready;
  assign pt_i.ready = en;
  assign acc        = pt_i.valid && en;

  // stage 0: counters and line store
  logic [AW-1:0]              col_q, col_d, col_c;
  logic [bapx_pkg::ROW_W-1:0] row_q, row_d, row_c;
  logic [CW-1:0]              col_inc;
  logic                       hit;
  bapx_pkg::meta_t            meta_c;
  bapx_pkg::point_t           cur;

  always_comb begin
    col_c   = pt_i.frame_start ? '0 : col_q;
    row_c   = pt_i.frame_start ? '0 : row_q;
    col_inc = CW'(col_c) + CW'(1);
    hit     = (row_c != '0) && (col_inc < ppr_eff) && (32'(row_c) < 32'(h_eff))
              && (32'(col_c) < 32'(w_eff));
    col_d   = (col_inc >= ppr_eff) ? '0 : col_inc[AW-1:0];
    row_d   = (col_inc >= ppr_eff && row_c != bapx_pkg::ROW_MAX) ? row_c + 1'b1 : row_c;
    meta_c.row = bapx_pkg::PIX_W'(32'(h_eff) - 32'(row_c) - 32'd1);
    meta_c.col = bapx_pkg::PIX_W'(32'(w_eff) - 32'(col_c) - 32'd1);
    cur.x = pt_i.pos_x;
    cur.y = pt_i.pos_y;
    cur.z = pt_i.pos_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic [$bits(bapx_pkg::point_t)-1:0] ram_rdata;

  bapx_ram #(
    .WIDTH($bits(bapx_pkg::point_t)),
    .DEPTH(MAX_ROW_POINTS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_c),
    .wdata_i (cur),
    .re_i    (en),
    .raddr_i (col_inc[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // stage 1: current point beside the previous row's neighbor
  logic             s1_vld_q;
  bapx_pkg::point_t s1_p_q;
  bapx_pkg::meta_t  s1_meta_q;
  bapx_pkg::point_t s1_q;

  assign s1_q = bapx_pkg::point_t'(ram_rdata);

  // stage 2: squares
  logic                       s2_vld_q;
  bapx_pkg::meta_t            s2_meta_q;
  logic [bapx_pkg::SQE_W-1:0] s2_p_q [3];
  logic [bapx_pkg::SQE_W-1:0] s2_d_q [3];
  logic [bapx_pkg::SQE_W-1:0] s2_c_q [3];

  // stage 3: |P|^2, |P-Q|^2, |Q|^2
  logic                      s3_vld_q;
  bapx_pkg::meta_t           s3_meta_q;
  logic [bapx_pkg::SQ_W-1:0] s3_a_q, s3_b_q, s3_c_q;

  // stage 4: law-of-cosines numerator
  logic                      s4_vld_q;
  logic [bapx_pkg::SQ_W-1:0] s4_a_q, s4_b_q;
  bapx_pkg::sqrt_side_t      s4_side_q;
  logic [bapx_pkg::NUM_W-1:0] ab_sum, c_ext;

  assign ab_sum = bapx_pkg::NUM_W'(s3_a_q) + bapx_pkg::NUM_W'(s3_b_q);
  assign c_ext  = bapx_pkg::NUM_W'(s3_c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= acc && hit;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_p_q    <= cur;
      s1_meta_q <= meta_c;

      s2_meta_q <= s1_meta_q;
      s2_p_q[0] <= bapx_pkg::sqr((KW+1)'(s1_p_q.x));
      s2_p_q[1] <= bapx_pkg::sqr((KW+1)'(s1_p_q.y));
      s2_p_q[2] <= bapx_pkg::sqr((KW+1)'(s1_p_q.z));
      s2_c_q[0] <= bapx_pkg::sqr((KW+1)'(s1_q.x));
      s2_c_q[1] <= bapx_pkg::sqr((KW+1)'(s1_q.y));
      s2_c_q[2] <= bapx_pkg::sqr((KW+1)'(s1_q.z));
      s2_d_q[0] <= bapx_pkg::sqr((KW+1)'(s1_p_q.x) - (KW+1)'(s1_q.x));
      s2_d_q[1] <= bapx_pkg::sqr((KW+1)'(s1_p_q.y) - (KW+1)'(s1_q.y));
      s2_d_q[2] <= bapx_pkg::sqr((KW+1)'(s1_p_q.z) - (KW+1)'(s1_q.z));

      s3_meta_q <= s2_meta_q;
      s3_a_q <= bapx_pkg::SQ_W'(s2_p_q[0]) + bapx_pkg::SQ_W'(s2_p_q[1])
                + bapx_pkg::SQ_W'(s2_p_q[2]);
      s3_b_q <= bapx_pkg::SQ_W'(s2_d_q[0]) + bapx_pkg::SQ_W'(s2_d_q[1])
                + bapx_pkg::SQ_W'(s2_d_q[2]);
      s3_c_q <= bapx_pkg::SQ_W'(s2_c_q[0]) + bapx_pkg::SQ_W'(s2_c_q[1])
                + bapx_pkg::SQ_W'(s2_c_q[2]);

      s4_a_q         <= s3_a_q;
      s4_b_q         <= s3_b_q;
      s4_side_q.meta <= s3_meta_q;
      s4_side_q.zero <= (s3_a_q == '0) || (s3_b_q == '0);
      s4_side_q.neg  <= ab_sum < c_ext;
      s4_side_q.num  <= (ab_sum < c_ext) ? c_ext - ab_sum : ab_sum - c_ext;
    end
  end

  // square roots of both lengths
  logic                        sq_vld;
  logic [bapx_pkg::ROOT_W-1:0] sq_ra, sq_rb;
  bapx_pkg::sqrt_side_t        sq_side;

  bapx_isqrt2 #(.STEPS(3)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .va_i   (s4_a_q),
    .vb_i   (s4_b_q),
    .side_i (s4_side_q),
    .vld_o  (sq_vld),
    .ra_o   (sq_ra),
    .rb_o   (sq_rb),
    .side_o (sq_side)
  );

  // stage 5: denominator 2ab
  logic                       s5_vld_q;
  logic [bapx_pkg::DEN_W-1:0] s5_den_q;
  logic [bapx_pkg::NUM_W-1:0] s5_num_q;
  bapx_pkg::div_side_t        s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_den_q       <= {bapx_pkg::SQ_W'(sq_ra) * bapx_pkg::SQ_W'(sq_rb), 1'b0};
      s5_num_q       <= sq_side.num;
      s5_side_q.meta <= sq_side.meta;
      s5_side_q.zero <= sq_side.zero;
      s5_side_q.neg  <= sq_side.neg;
    end
  end

  logic                       dv_vld;
  logic [bapx_pkg::QUO_W-1:0] dv_quo;
  logic                       dv_ovf;
  bapx_pkg::div_side_t        dv_side;

  bapx_divq #(.STEPS(3)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .num_i  (s5_num_q),
    .den_i  (s5_den_q),
    .side_i (s5_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf),
    .side_o (dv_side)
  );

  bapx_pkg::meta_t out_meta;

  bapx_gray #(.STEPS(2)) u_gray (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld),
    .quo_i  (dv_quo),
    .ovf_i  (dv_ovf),
    .side_i (dv_side),
    .vld_o  (out_vld),
    .gray_o (px_o.gray_level),
    .meta_o (out_meta)
  );

  assign px_o.valid     = out_vld;
  assign px_o.pixel_row = out_meta.row;
  assign px_o.pixel_col = out_meta.col;

`ifndef SYNTHESIS
  // input is held back only by a pixel waiting at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pt_i.ready |-> (px_o.valid && !px_o.ready))
    else $error("input stalled without output backpressure");

  // a frame start beat restarts the scan at row 0, column 1
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_i.valid && pt_i.ready && pt_i.frame_start) |=> (col_q == AW'(1) && row_q == '0))
    else $error("frame start did not restart counters");
`endif

endmodule

// File: test/bapx_checker.sv
`timescale 1ns / 1ps

module bapx_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  bapx_cfg_if        cfg,
  bapx_in_if         pt,
  bapx_out_if        px,
  output int         err_cnt_o,
  output int         pending_o
);

  localparam int LINE_LEN = 1024;
  localparam int DIM_MAX  = 4096;

  typedef struct {
    logic [bapx_pkg::GRAY_W-1:0] gray;
    logic [bapx_pkg::PIX_W-1:0]  row;
    logic [bapx_pkg::PIX_W-1:0]  col;
  } pixel_t;

  pixel_t                      pixel_q[$];
  longint                      cos_q16[256];
  longint                      line_x[LINE_LEN];
  longint                      line_y[LINE_LEN];
  longint                      line_z[LINE_LEN];
  logic [bapx_pkg::ROW_W-1:0]  scan_row;
  int unsigned                 scan_col;
  logic [bapx_pkg::PPR_W-1:0]  ppr_reg;
  logic [bapx_pkg::DIM_W-1:0]  width_reg;
  logic [bapx_pkg::DIM_W-1:0]  height_reg;

  assign pending_o = pixel_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sum_sq(longint a, longint b, longint c);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned mc;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    mc = c < 0 ? -c : c;
    return ma * ma + mb * mb + mc * mc;
  endfunction

  // law of cosines at p, gray = count of table entries past index 0 at or above the cosine
  function automatic logic [bapx_pkg::GRAY_W-1:0] bearing_gray(
      longint px_, longint py, longint pz, longint qx, longint qy, longint qz);
    longint unsigned beam_sq;
    longint unsigned seg_sq;
    longint unsigned far_sq;
    longint unsigned den;
    longint unsigned num;
    longint unsigned quo;
    longint          cosv;
    logic            neg;
    int              cnt;
    beam_sq = sum_sq(px_, py, pz);
    seg_sq  = sum_sq(px_ - qx, py - qy, pz - qz);
    far_sq  = sum_sq(qx, qy, qz);
    if (beam_sq == 0 || seg_sq == 0) return '0;
    den = 2 * int_sqrt(beam_sq) * int_sqrt(seg_sq);
    if (beam_sq + seg_sq >= far_sq) begin
      num = beam_sq + seg_sq - far_sq;
      neg = 1'b0;
    end else begin
      num = far_sq - (beam_sq + seg_sq);
      neg = 1'b1;
    end
    quo = (num << 16) / den;
    if (quo > 65536) quo = 65536;
    cosv = neg ? -longint'(quo) : longint'(quo);
    cnt = 0;
    for (int g = 1; g < 256; g++) if (cos_q16[g] >= cosv) cnt++;
    return bapx_pkg::GRAY_W'(cnt);
  endfunction

  initial begin
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned q;
    longint          acc;
    for (int g = 0; g < 128; g++) begin
      t = (longint'(g) * 64'd13493037705 + 64'd510) / 64'd1020;
      t2 = (t * t + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      acc = longint'(term);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * t2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (longint'(acc) + (64'd1 << 13)) >> 14;
      cos_q16[g] = longint'(q);
      cos_q16[255-g] = -longint'(q);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned ppr;
    int unsigned w;
    int unsigned h;
    int unsigned c;
    pixel_t      exp_px;
    pixel_t      got;
    if (!rst_ni) begin
      scan_row   = '0;
      scan_col   = 0;
      ppr_reg    <= bapx_pkg::PPR_RST;
      width_reg  <= bapx_pkg::DIM_RST;
      height_reg <= bapx_pkg::DIM_RST;
      err_cnt_o  <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (bapx_pkg::cfg_reg_e'(cfg.index))
          bapx_pkg::CFG_PPR:    ppr_reg <= bapx_pkg::PPR_W'(cfg.data);
          bapx_pkg::CFG_WIDTH:  width_reg <= cfg.data;
          bapx_pkg::CFG_HEIGHT: height_reg <= cfg.data;
          default: ;
        endcase
      end
      if (px.valid && px.ready) begin
        got.gray = px.gray_level;
        got.row  = px.pixel_row;
        got.col  = px.pixel_col;
        if (pixel_q.size() == 0) begin
          $display("%0t: pixel beat with none expected: gray %0d row %0d col %0d",
                   $time, got.gray, got.row, got.col);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          if (got.gray !== exp_px.gray || got.row !== exp_px.row || got.col !== exp_px.col) begin
            $display("%0t: pixel mismatch: expected gray %0d row %0d col %0d, got %0d %0d %0d",
                     $time, exp_px.gray, exp_px.row, exp_px.col, got.gray, got.row, got.col);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (pt.valid && pt.ready) begin
        ppr = ppr_reg < 2 ? 2 : (ppr_reg > LINE_LEN ? LINE_LEN : ppr_reg);
        w = width_reg > DIM_MAX ? DIM_MAX : width_reg;
        h = height_reg > DIM_MAX ? DIM_MAX : height_reg;
        if (pt.frame_start) begin
          scan_row = '0;
          scan_col = 0;
        end
        c = scan_col % LINE_LEN;
        if (scan_row >= 1 && c + 1 < ppr && scan_row < h && c < w) begin
          exp_px.gray = bearing_gray(longint'(pt.pos_x), longint'(pt.pos_y), longint'(pt.pos_z),
                                     line_x[c+1], line_y[c+1], line_z[c+1]);
          exp_px.row = bapx_pkg::PIX_W'(h - scan_row - 1);
          exp_px.col = bapx_pkg::PIX_W'(w - c - 1);
          pixel_q = {pixel_q, exp_px};
        end
        line_x[c] = longint'(pt.pos_x);
        line_y[c] = longint'(pt.pos_y);
        line_z[c] = longint'(pt.pos_z);
        c++;
        if (c >= ppr) begin
          c = 0;
          if (scan_row < bapx_pkg::ROW_MAX) scan_row = scan_row + 1'b1;
        end
        scan_col = c;
      end
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYC   = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   err_cnt;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   hold_req_n = 0;
  int   hold_done_n = 0;
  int   hold_cnt = 0;
  int   quiet = 0;

  bapx_cfg_if cfg_if ();
  bapx_in_if  pt_if ();
  bapx_out_if px_if ();

  bearing_angle_pixel_stream_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pt_i   (pt_if),
    .px_o   (px_if)
  );

  bapx_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg       (cfg_if),
    .pt        (pt_if),
    .px        (px_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req_n != hold_done_n) begin
      hold_done_n = hold_req_n;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      px_if.ready <= 1'b0;
    end else begin
      px_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((pt_if.valid && pt_if.ready) || (px_if.valid && px_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic reg_write(bapx_pkg::cfg_reg_e idx, int data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= bapx_pkg::DIM_W'(data);
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_point(int x, int y, int z, bit fs);
    while ($urandom_range(99) < idle_pct) begin
      pt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_if.valid       <= 1'b1;
    pt_if.pos_x       <= bapx_pkg::COORD_W'(x);
    pt_if.pos_y       <= bapx_pkg::COORD_W'(y);
    pt_if.pos_z       <= bapx_pkg::COORD_W'(z);
    pt_if.frame_start <= fs;
    do @(posedge clk_i); while (!pt_if.ready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    pt_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  function automatic int noise(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // mostly smooth surface points, some full-range and near-origin noise
  task automatic scan_pass(int ppr, int w, int h, int n, bit fresh, int mode, int hold_at);
    int k;
    int sel;
    idle_pct  = (mode == 1 || mode == 3) ? (mode == 1 ? 65 : 19) : 0;
    stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 65 : 19) : 0;
    reg_write(bapx_pkg::CFG_PPR, ppr);
    reg_write(bapx_pkg::CFG_WIDTH, w);
    reg_write(bapx_pkg::CFG_HEIGHT, h);
    for (k = 0; k < n; k++) begin
      if (k == hold_at) hold_req_n++;
      sel = $urandom_range(99);
      if (sel < 80) begin
        send_point((k % 64) * 50 + noise(30), (k / 64) * 40 + noise(30),
                   3000 + noise(400), (k == 0 && fresh) || sel == 0);
      end else if (sel < 90) begin
        send_point($urandom, $urandom, $urandom, k == 0 && fresh);
      end else begin
        send_point(noise(2), noise(2), noise(2), k == 0 && fresh);
      end
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cfg_if.valid = 1'b0;
    cfg_if.index = bapx_pkg::CFG_PPR;
    cfg_if.data = '0;
    pt_if.valid = 1'b0;
    pt_if.pos_x = '0;
    pt_if.pos_y = '0;
    pt_if.pos_z = '0;
    pt_if.frame_start = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: rows of four, oversized image dims saturate
    reg_write(bapx_pkg::CFG_PPR, 4);
    reg_write(bapx_pkg::CFG_WIDTH, 8191);
    reg_write(bapx_pkg::CFG_HEIGHT, 8191);
    send_point(1, 2, 3, 1'b1);
    send_point(4, 5, 6, 1'b1);
    send_point(524287, 524287, 524287, 1'b0);
    send_point(-524288, -524288, -524288, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(-524288, -524288, -524288, 1'b0);
    send_point(524287, 524287, 524287, 1'b0);
    send_point(5, 0, 0, 1'b0);
    send_point(1, 1, 1, 1'b0);
    // segment of zero length and zero beam
    send_point(524287, 524287, 524287, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(1, 1, 1, 1'b0);
    send_point(7, -3, 2, 1'b0);
    send_point(1000, 0, 0, 1'b0);
    send_point(-1000, 10, 10, 1'b0);
    send_point(3, 4, 5, 1'b0);
    send_point(9, 9, 9, 1'b0);
    send_point(2000, 0, 0, 1'b0);
    send_point(-1000, 10, 10, 1'b0);
    send_point(-3, -4, -5, 1'b0);
    send_point(9, 9, 9, 1'b0);
    settle();

    // row length below minimum, one-column image
    scan_pass(0, 1, 4096, 60, 1'b1, 1, -1);
    scan_pass(1, 2, 3, 40, 1'b1, 0, -1);
    // row length above maximum
    scan_pass(2047, 4096, 2, 150, 1'b1, 3, -1);
    // image narrower than the row, pixels dropped
    scan_pass(5, 3, 6, 100, 1'b1, 2, -1);
    // long output hold-off so the pipe backs up; ends mid-row
    scan_pass(8, 16, 16, 150, 1'b1, 0, 40);
    // shrink the row while the column is past the new end
    scan_pass(3, 16, 16, 60, 1'b0, 3, -1);
    scan_pass(6, 4096, 4096, 80, 1'b1, 1, -1);
    // two-point rows in a two-column image
    scan_pass(2, 2, 4096, 60, 1'b1, 0, -1);
    scan_pass(7, 1024, 1024, 60, 1'b1, 2, -1);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
